// File: sv/rtte_pkg.sv
// Shared types, widths and constants of the RTT estimator.
package rtte_pkg;

    localparam int SRTT_SHIFT   = 3;
    localparam int VAR_SHIFT    = 2;
    localparam int VAR_GAIN_EXP = 2;
    localparam int FRAC_BITS    = 16;

    localparam int SAMPLE_W = 32;
    localparam int TICK_W   = 20;
    localparam int MINR_W   = 32;
    localparam int RTO_W    = 37;
    localparam int WQ_W     = 16;
    localparam int MULT_W   = 4;
    localparam int FLOOR_W  = 32;
    localparam int TST_W    = 32;
    localparam int DELTA_W  = 16;
    localparam int OUT32_W  = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 37;

    // fixed-point EWMA and the shared multiply-accumulate unit
    localparam int EW_W     = SAMPLE_W + FRAC_BITS;
    localparam int CHUNK_W  = (EW_W + 1) / 2;
    localparam int WT_W     = WQ_W + 1;
    localparam int PROD_W   = CHUNK_W + WT_W;
    localparam int ACC_W    = EW_W + WQ_W + 1;
    localparam int KRV_W    = EW_W + MULT_W;
    localparam int SUM_W    = KRV_W + 1;
    localparam int MIX_STEPS = 4;
    localparam int KRV_STEPS = 2;

    // tick rounding divider: (2*sample + tick) / (2*tick)
    localparam int NUM_W = SAMPLE_W + 2;
    localparam int DEN_W = TICK_W + 1;
    localparam int CNT_W = $clog2(NUM_W + 1);

    // t0 = ((var << e) + srtt) >> SRTT_SHIFT, e may be negative
    localparam int T0_E     = VAR_GAIN_EXP + SRTT_SHIFT - VAR_SHIFT;
    localparam int T0_LSH   = (T0_E > 0) ? T0_E : 0;
    localparam int T0_RSH   = (T0_E < 0) ? -T0_E : 0;
    localparam int T0_SUM_W = TST_W + T0_LSH + 1;
    localparam int T0_B_W   = T0_SUM_W - SRTT_SHIFT;
    localparam int T0_P_W   = T0_B_W + TICK_W;

    localparam logic [TST_W-1:0] TICK_SRTT_RST = 32'd9600;
    localparam logic [TST_W-1:0] TICK_VAR_RST  = 32'd1200;
    localparam logic [RTO_W-1:0] RTO_RST       = 37'd3000000;

    localparam logic [TICK_W-1:0]  TICK_US_RST    = 20'd10000;
    localparam logic [MINR_W-1:0]  MIN_RTO_RST    = 32'd0;
    localparam logic [RTO_W-1:0]   MAX_RTO_RST    = 37'd100000000000;
    localparam logic [WQ_W-1:0]    DECAY_RST      = 16'd62259;
    localparam logic [WQ_W-1:0]    BETA_RST       = 16'd16384;
    localparam logic [MULT_W-1:0]  VAR_MULT_RST   = 4'd4;
    localparam logic [FLOOR_W-1:0] RTO_FLOOR_RST  = 32'd10000;

    localparam logic [CFG_IDX_W-1:0] CFG_TICK_US      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RTO_US   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RTO_US   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_Q16    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA_Q16     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_VAR_MULT     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_RTO_FLOOR_US = 3'd6;

    typedef struct packed {
        logic [SAMPLE_W-1:0] rtt_sample_us;
        logic                timeout_driven;
    } in_item_t;

    typedef struct packed {
        logic [OUT32_W-1:0] t0_us;
        logic [RTO_W-1:0]   rto_us;
        logic [OUT32_W-1:0] srtt_us;
        logic [OUT32_W-1:0] rttvar_us;
    } out_item_t;

    typedef struct packed {
        logic [TICK_W-1:0]  tick_us;
        logic [MINR_W-1:0]  min_rto_us;
        logic [RTO_W-1:0]   max_rto_us;
        logic [WQ_W-1:0]    decay_q16;
        logic [WQ_W-1:0]    beta_q16;
        logic [MULT_W-1:0]  var_mult;
        logic [FLOOR_W-1:0] rto_floor_us;
    } cfg_t;

    typedef enum logic [1:0] {
        MAC_SRTT,
        MAC_VAR,
        MAC_KRV
    } mac_sel_t;

    typedef struct packed {
        logic     load;
        logic     div_step;
        logic     tick_srtt;
        logic     tick_var;
        logic     t0_mul;
        logic     ewma_init;
        logic     acc_clr;
        logic     acc_round;
        logic     acc_add;
        mac_sel_t mac_sel;
        logic [1:0] mac_step;
        logic     srtt_wr;
        logic     dev_wr;
        logic     var_wr;
        logic     rto_sum;
        logic     rto_clamp;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic ewma_seen;
        logic tdriven;
        logic out_free;
    } status_t;

endpackage

// File: sv/rtte_ctrl.sv
// Sequencer that steps one RTT sample through the estimator datapath.
module rtte_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  rtte_pkg::status_t status,
    output rtte_pkg::cmd_t    cmd
);

    typedef enum logic [14:0] {
        S_IDLE    = 15'b000000000000001,
        S_DIV     = 15'b000000000000010,
        S_TICK_S  = 15'b000000000000100,
        S_TICK_V  = 15'b000000000001000,
        S_T0_MUL  = 15'b000000000010000,
        S_EW_INIT = 15'b000000000100000,
        S_MIX_S   = 15'b000000001000000,
        S_SRTT_WR = 15'b000000010000000,
        S_DEV     = 15'b000000100000000,
        S_MIX_V   = 15'b000001000000000,
        S_VAR_WR  = 15'b000010000000000,
        S_KRV     = 15'b000100000000000,
        S_RTO_SUM = 15'b001000000000000,
        S_CLAMP   = 15'b010000000000000,
        S_OUT     = 15'b100000000000000
    } state_t;

    state_t                    state_reg, state_next;
    logic [rtte_pkg::CNT_W-1:0] cnt_reg, cnt_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = '0;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == rtte_pkg::CNT_W'(rtte_pkg::NUM_W - 1))
                begin
                    state_next = S_TICK_S;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_TICK_S:
            begin
                cmd.tick_srtt = 1'b1;
                state_next    = S_TICK_V;
            end
            S_TICK_V:
            begin
                cmd.tick_var = 1'b1;
                state_next   = S_T0_MUL;
            end
            S_T0_MUL:
            begin
                cmd.t0_mul    = 1'b1;
                cmd.acc_clr   = 1'b1;
                cmd.acc_round = 1'b1;
                state_next    = status.ewma_seen ? S_MIX_S : S_EW_INIT;
            end
            S_EW_INIT:
            begin
                cmd.ewma_init = 1'b1;
                cmd.acc_clr   = 1'b1;
                state_next    = status.tdriven ? S_CLAMP : S_KRV;
            end
            S_MIX_S:
            begin
                cmd.acc_add  = 1'b1;
                cmd.mac_sel  = rtte_pkg::MAC_SRTT;
                cmd.mac_step = cnt_reg[1:0];
                if (cnt_reg == rtte_pkg::CNT_W'(rtte_pkg::MIX_STEPS - 1))
                begin
                    state_next = S_SRTT_WR;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_SRTT_WR:
            begin
                cmd.srtt_wr = 1'b1;
                state_next  = S_DEV;
            end
            S_DEV:
            begin
                cmd.dev_wr    = 1'b1;
                cmd.acc_clr   = 1'b1;
                cmd.acc_round = 1'b1;
                state_next    = S_MIX_V;
            end
            S_MIX_V:
            begin
                cmd.acc_add  = 1'b1;
                cmd.mac_sel  = rtte_pkg::MAC_VAR;
                cmd.mac_step = cnt_reg[1:0];
                if (cnt_reg == rtte_pkg::CNT_W'(rtte_pkg::MIX_STEPS - 1))
                begin
                    state_next = S_VAR_WR;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_VAR_WR:
            begin
                cmd.var_wr  = 1'b1;
                cmd.acc_clr = 1'b1;
                state_next  = status.tdriven ? S_CLAMP : S_KRV;
            end
            S_KRV:
            begin
                // only the low operand is used, so walk its two chunks
                cmd.acc_add  = 1'b1;
                cmd.mac_sel  = rtte_pkg::MAC_KRV;
                cmd.mac_step = {1'b0, cnt_reg[0]};
                if (cnt_reg == rtte_pkg::CNT_W'(rtte_pkg::KRV_STEPS - 1))
                begin
                    state_next = S_RTO_SUM;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_RTO_SUM:
            begin
                cmd.rto_sum = 1'b1;
                state_next  = S_CLAMP;
            end
            S_CLAMP:
            begin
                cmd.rto_clamp = 1'b1;
                state_next    = S_OUT;
            end
            S_OUT:
            begin
                // hold until the output register can take the result
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == S_DIV) && (cnt_reg == '0))
        else $error("sample load did not start the divider");

    a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TICK_S) |-> $past(state_reg == S_DIV)
            && ($past(cnt_reg) == rtte_pkg::CNT_W'(rtte_pkg::NUM_W - 1)))
        else $error("divider left before its last step");

    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_OUT) && !status.out_free) |=> (state_reg == S_OUT))
        else $error("result dropped while output register busy");

endmodule

// File: sv/rtte_dp.sv
// Datapath: tick divider, smoothed tick estimator, EWMA MAC unit and result register.
module rtte_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  rtte_pkg::cmd_t      cmd,
    input  rtte_pkg::cfg_t      cfg,
    input  rtte_pkg::in_item_t  in_item,
    input  logic                out_stall,
    output rtte_pkg::status_t   status,
    output logic                out_valid,
    output rtte_pkg::out_item_t out_item
);

    function automatic logic [rtte_pkg::TST_W-1:0] clamp_pos(
        input logic [rtte_pkg::TST_W-1:0] v);
        logic [rtte_pkg::TST_W-1:0] r;
        begin
            r = v;
            if ((v == '0) || v[rtte_pkg::TST_W-1])
            begin
                r = rtte_pkg::TST_W'(1);
            end
            return r;
        end
    endfunction

    logic [rtte_pkg::SAMPLE_W-1:0] sample_reg;
    logic                          tdriven_reg;
    logic [rtte_pkg::NUM_W-1:0]    dq_reg, dq_next;
    logic [rtte_pkg::DEN_W-1:0]    rem_reg, rem_next;
    logic [rtte_pkg::TST_W-1:0]    tick_srtt_reg, tick_srtt_next;
    logic [rtte_pkg::TST_W-1:0]    tick_var_reg, tick_var_next;
    logic [rtte_pkg::DELTA_W-1:0]  delta_reg, delta_next;
    logic [rtte_pkg::T0_P_W-1:0]   t0p_reg, t0p_next;
    logic [rtte_pkg::EW_W-1:0]     ewma_srtt_reg, ewma_srtt_next;
    logic [rtte_pkg::EW_W-1:0]     ewma_var_reg, ewma_var_next;
    logic                          ewma_seen_reg, ewma_seen_next;
    logic [rtte_pkg::EW_W-1:0]     dev_reg, dev_next;
    logic [rtte_pkg::ACC_W-1:0]    acc_reg, acc_next;
    logic [rtte_pkg::RTO_W-1:0]    rto_reg, rto_next;
    logic                          out_valid_reg, out_valid_next;
    rtte_pkg::out_item_t           out_item_reg, out_item_next;

    logic [rtte_pkg::TICK_W-1:0]   tick_eff;
    logic [rtte_pkg::DEN_W-1:0]    den;
    logic [rtte_pkg::DEN_W:0]      rem_sh;
    logic                          rem_ge;

    logic [rtte_pkg::DELTA_W-1:0]  trtt_lo, delta, mag, d2;
    logic [rtte_pkg::T0_SUM_W-1:0] t0_sum;
    logic [rtte_pkg::T0_B_W-1:0]   t0_base;
    logic [rtte_pkg::OUT32_W-1:0]  t0_out;

    logic [rtte_pkg::EW_W-1:0]     s_q;
    logic [rtte_pkg::EW_W-1:0]     op_a, op_b, mac_op;
    logic [rtte_pkg::WT_W-1:0]     wt_a, wt_b, mac_wt;
    logic [rtte_pkg::CHUNK_W-1:0]  chunk;
    logic [rtte_pkg::PROD_W-1:0]   prod;
    logic [rtte_pkg::ACC_W-1:0]    addend;
    logic [rtte_pkg::EW_W-1:0]     mix_res;

    logic [rtte_pkg::KRV_W-1:0]    krv, floor_q, margin;
    logic [rtte_pkg::SUM_W-1:0]    rto_sum;
    logic [rtte_pkg::EW_W:0]       s_rnd, v_rnd;
    logic [rtte_pkg::OUT32_W:0]    s_us, v_us;

    assign tick_eff = (cfg.tick_us == '0) ? rtte_pkg::TICK_W'(1) : cfg.tick_us;
    assign den      = {tick_eff, 1'b0};

    // restoring divider, one quotient bit per cycle
    assign rem_sh = {rem_reg, dq_reg[rtte_pkg::NUM_W-1]};
    assign rem_ge = (rem_sh >= {1'b0, den});

    // tick estimator; deltas wrap in 16 bits
    assign trtt_lo = (dq_reg == '0) ? rtte_pkg::DELTA_W'(1) : dq_reg[rtte_pkg::DELTA_W-1:0];
    assign delta   = trtt_lo - tick_srtt_reg[rtte_pkg::SRTT_SHIFT +: rtte_pkg::DELTA_W];
    assign mag     = delta_reg[rtte_pkg::DELTA_W-1] ? (rtte_pkg::DELTA_W'(0) - delta_reg)
                                                     : delta_reg;
    assign d2      = mag - tick_var_reg[rtte_pkg::VAR_SHIFT +: rtte_pkg::DELTA_W];

    assign t0_sum  = ((rtte_pkg::T0_SUM_W'(tick_var_reg) << rtte_pkg::T0_LSH)
                      >> rtte_pkg::T0_RSH) + rtte_pkg::T0_SUM_W'(tick_srtt_reg);
    assign t0_base = t0_sum[rtte_pkg::T0_SUM_W-1:rtte_pkg::SRTT_SHIFT];

    always_comb
    begin
        if (t0p_reg[rtte_pkg::T0_P_W-1:rtte_pkg::OUT32_W] != '0)
        begin
            t0_out = '1;
        end
        else if (t0p_reg[rtte_pkg::OUT32_W-1:0] < cfg.min_rto_us)
        begin
            t0_out = cfg.min_rto_us;
        end
        else
        begin
            t0_out = t0p_reg[rtte_pkg::OUT32_W-1:0];
        end
    end

    // multiply-accumulate: one chunk times one weight per cycle
    assign s_q = rtte_pkg::EW_W'(sample_reg) << rtte_pkg::FRAC_BITS;

    always_comb
    begin
        unique case (cmd.mac_sel)
            rtte_pkg::MAC_SRTT:
            begin
                op_a = ewma_srtt_reg;
                op_b = s_q;
                wt_a = {1'b0, cfg.decay_q16};
            end
            rtte_pkg::MAC_VAR:
            begin
                op_a = dev_reg;
                op_b = ewma_var_reg;
                wt_a = {1'b0, cfg.beta_q16};
            end
            rtte_pkg::MAC_KRV:
            begin
                op_a = ewma_var_reg;
                op_b = '0;
                wt_a = rtte_pkg::WT_W'(cfg.var_mult);
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
                wt_a = '0;
            end
        endcase
    end

    assign wt_b    = (rtte_pkg::WT_W'(1) << rtte_pkg::WQ_W) - wt_a;
    assign mac_op  = cmd.mac_step[1] ? op_b : op_a;
    assign mac_wt  = cmd.mac_step[1] ? wt_b : wt_a;
    assign chunk   = cmd.mac_step[0] ? rtte_pkg::CHUNK_W'(mac_op >> rtte_pkg::CHUNK_W)
                                     : mac_op[rtte_pkg::CHUNK_W-1:0];
    assign prod    = chunk * mac_wt;
    assign addend  = rtte_pkg::ACC_W'(prod) << (cmd.mac_step[0] ? rtte_pkg::CHUNK_W : 0);
    assign mix_res = acc_reg[rtte_pkg::WQ_W +: rtte_pkg::EW_W];

    assign krv     = acc_reg[rtte_pkg::KRV_W-1:0];
    assign floor_q = rtte_pkg::KRV_W'(cfg.rto_floor_us) << rtte_pkg::FRAC_BITS;
    assign margin  = (krv > floor_q) ? krv : floor_q;
    assign rto_sum = rtte_pkg::SUM_W'(ewma_srtt_reg) + rtte_pkg::SUM_W'(margin)
                     + (rtte_pkg::SUM_W'(1) << (rtte_pkg::FRAC_BITS - 1));

    assign s_rnd = (rtte_pkg::EW_W + 1)'(ewma_srtt_reg)
                   + ((rtte_pkg::EW_W + 1)'(1) << (rtte_pkg::FRAC_BITS - 1));
    assign v_rnd = (rtte_pkg::EW_W + 1)'(ewma_var_reg)
                   + ((rtte_pkg::EW_W + 1)'(1) << (rtte_pkg::FRAC_BITS - 1));
    assign s_us  = s_rnd[rtte_pkg::FRAC_BITS +: (rtte_pkg::OUT32_W + 1)];
    assign v_us  = v_rnd[rtte_pkg::FRAC_BITS +: (rtte_pkg::OUT32_W + 1)];

    always_comb
    begin
        dq_next        = dq_reg;
        rem_next       = rem_reg;
        tick_srtt_next = tick_srtt_reg;
        tick_var_next  = tick_var_reg;
        delta_next     = delta_reg;
        t0p_next       = t0p_reg;
        ewma_srtt_next = ewma_srtt_reg;
        ewma_var_next  = ewma_var_reg;
        ewma_seen_next = ewma_seen_reg;
        dev_next       = dev_reg;
        acc_next       = acc_reg;
        rto_next       = rto_reg;
        out_item_next  = out_item_reg;
        out_valid_next = out_valid_reg && out_stall;

        if (cmd.load)
        begin
            dq_next  = rtte_pkg::NUM_W'({in_item.rtt_sample_us, 1'b0})
                       + rtte_pkg::NUM_W'(tick_eff);
            rem_next = '0;
        end
        if (cmd.div_step)
        begin
            rem_next = rem_ge ? rtte_pkg::DEN_W'(rem_sh - {1'b0, den})
                              : rem_sh[rtte_pkg::DEN_W-1:0];
            dq_next  = {dq_reg[rtte_pkg::NUM_W-2:0], rem_ge};
        end
        if (cmd.tick_srtt)
        begin
            delta_next     = delta;
            tick_srtt_next = clamp_pos(tick_srtt_reg
                + {{(rtte_pkg::TST_W - rtte_pkg::DELTA_W){delta[rtte_pkg::DELTA_W-1]}}, delta});
        end
        if (cmd.tick_var)
        begin
            tick_var_next = clamp_pos(tick_var_reg
                + {{(rtte_pkg::TST_W - rtte_pkg::DELTA_W){d2[rtte_pkg::DELTA_W-1]}}, d2});
        end
        if (cmd.t0_mul)
        begin
            t0p_next = t0_base * tick_eff;
        end
        if (cmd.ewma_init)
        begin
            ewma_srtt_next = s_q;
            ewma_var_next  = rtte_pkg::EW_W'(sample_reg) << (rtte_pkg::FRAC_BITS - 1);
            ewma_seen_next = 1'b1;
        end
        if (cmd.acc_clr)
        begin
            acc_next = cmd.acc_round ? (rtte_pkg::ACC_W'(1) << (rtte_pkg::WQ_W - 1)) : '0;
        end
        if (cmd.acc_add)
        begin
            acc_next = acc_reg + addend;
        end
        if (cmd.srtt_wr)
        begin
            ewma_srtt_next = mix_res;
        end
        if (cmd.dev_wr)
        begin
            dev_next = (ewma_srtt_reg > s_q) ? (ewma_srtt_reg - s_q) : (s_q - ewma_srtt_reg);
        end
        if (cmd.var_wr)
        begin
            ewma_var_next = mix_res;
        end
        if (cmd.rto_sum)
        begin
            rto_next = rto_sum[rtte_pkg::FRAC_BITS +: rtte_pkg::RTO_W];
        end
        if (cmd.rto_clamp && (rto_reg > cfg.max_rto_us))
        begin
            rto_next = cfg.max_rto_us;
        end
        if (cmd.out_load)
        begin
            out_item_next.t0_us     = t0_out;
            out_item_next.rto_us    = rto_reg;
            out_item_next.srtt_us   = s_us[rtte_pkg::OUT32_W] ? '1 : s_us[rtte_pkg::OUT32_W-1:0];
            out_item_next.rttvar_us = v_us[rtte_pkg::OUT32_W] ? '1 : v_us[rtte_pkg::OUT32_W-1:0];
            out_valid_next          = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_srtt_reg <= rtte_pkg::TICK_SRTT_RST;
            tick_var_reg  <= rtte_pkg::TICK_VAR_RST;
            ewma_srtt_reg <= '0;
            ewma_var_reg  <= '0;
            ewma_seen_reg <= 1'b0;
            rto_reg       <= rtte_pkg::RTO_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            tick_srtt_reg <= tick_srtt_next;
            tick_var_reg  <= tick_var_next;
            ewma_srtt_reg <= ewma_srtt_next;
            ewma_var_reg  <= ewma_var_next;
            ewma_seen_reg <= ewma_seen_next;
            rto_reg       <= rto_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sample_reg  <= in_item.rtt_sample_us;
            tdriven_reg <= in_item.timeout_driven;
        end
        dq_reg       <= dq_next;
        rem_reg      <= rem_next;
        delta_reg    <= delta_next;
        t0p_reg      <= t0p_next;
        dev_reg      <= dev_next;
        acc_reg      <= acc_next;
        out_item_reg <= out_item_next;
    end

    assign status.ewma_seen = ewma_seen_reg;
    assign status.tdriven   = tdriven_reg;
    assign status.out_free  = !out_valid_reg || !out_stall;
    assign out_valid        = out_valid_reg;
    assign out_item         = out_item_reg;

    a_srtt_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (tick_srtt_reg != '0) && !tick_srtt_reg[rtte_pkg::TST_W-1])
        else $error("tick srtt left the positive range");

    a_var_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (tick_var_reg != '0) && !tick_var_reg[rtte_pkg::TST_W-1])
        else $error("tick variance left the positive range");

    a_seen_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        ewma_seen_reg |=> ewma_seen_reg)
        else $error("EWMA seen flag cleared after a sample");

    a_clamp_max: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rto_clamp |=> (rto_reg <= cfg.max_rto_us))
        else $error("RTO above maximum after clamp");

endmodule

// File: sv/rtt_estimator_rto.sv
// Top level of the RTT estimator: configuration registers, sequencer and datapath.
//
// Takes one RTT sample per acknowledgment and returns one result: the tick-based
// timeout estimate t0_us, the retransmission timeout rto_us and the EWMA srtt_us and
// rttvar_us. A sample goes through the one-bit-per-cycle restoring divider that rounds
// it to timer ticks, the tick estimator, the t0 multiply, the EWMA mixes, the variance
// multiple, the RTO sum and the clamp; timeout_driven skips the variance multiple and
// the RTO sum, and the first sample after reset seeds the EWMA instead of mixing. The
// EWMA mixes and the variance multiple go through one 24x17 multiply-accumulate
// unit, which walks the operands chunk by chunk. in_stall is high from
// acceptance until the result is loaded into the output register, so the next sample
// can be taken the cycle after that even while the previous result is still stalled.
// cfg_ready is always high; write registers only while no sample is in flight.
module rtt_estimator_rto (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  rtte_pkg::in_item_t                in_item,
    output logic                              out_valid,
    input  logic                              out_stall,
    output rtte_pkg::out_item_t               out_item,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rtte_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rtte_pkg::CFG_DATA_W-1:0]   cfg_data
);

    rtte_pkg::cfg_t    cfg_reg, cfg_next;
    rtte_pkg::cmd_t    cmd;
    rtte_pkg::status_t status;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                rtte_pkg::CFG_TICK_US:
                    cfg_next.tick_us = cfg_data[rtte_pkg::TICK_W-1:0];
                rtte_pkg::CFG_MIN_RTO_US:
                    cfg_next.min_rto_us = cfg_data[rtte_pkg::MINR_W-1:0];
                rtte_pkg::CFG_MAX_RTO_US:
                    cfg_next.max_rto_us = cfg_data[rtte_pkg::RTO_W-1:0];
                rtte_pkg::CFG_DECAY_Q16:
                    cfg_next.decay_q16 = cfg_data[rtte_pkg::WQ_W-1:0];
                rtte_pkg::CFG_BETA_Q16:
                    cfg_next.beta_q16 = cfg_data[rtte_pkg::WQ_W-1:0];
                rtte_pkg::CFG_VAR_MULT:
                    cfg_next.var_mult = cfg_data[rtte_pkg::MULT_W-1:0];
                rtte_pkg::CFG_RTO_FLOOR_US:
                    cfg_next.rto_floor_us = cfg_data[rtte_pkg::FLOOR_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tick_us      <= rtte_pkg::TICK_US_RST;
            cfg_reg.min_rto_us   <= rtte_pkg::MIN_RTO_RST;
            cfg_reg.max_rto_us   <= rtte_pkg::MAX_RTO_RST;
            cfg_reg.decay_q16    <= rtte_pkg::DECAY_RST;
            cfg_reg.beta_q16     <= rtte_pkg::BETA_RST;
            cfg_reg.var_mult     <= rtte_pkg::VAR_MULT_RST;
            cfg_reg.rto_floor_us <= rtte_pkg::RTO_FLOOR_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    rtte_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    rtte_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg       (cfg_reg),
        .in_item   (in_item),
        .out_stall (out_stall),
        .status    (status),
        .out_valid (out_valid),
        .out_item  (out_item)
    );

endmodule
